// ----- src/ttcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text terminal cell writer package
// Request, result and cell types, command codes and character constants.
// ----------------------------------------------------------------------------
package ttcw_pkg;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } req_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attribute;
    logic [10:0] cursor_pos;
  } rsp_t;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] ch;
  } cell_t;

  localparam cell_t CELL_BLANK = '{attr: ATTR_RESET, ch: CH_SPACE};

endpackage

// ----- src/text_terminal_cell_writer.sv -----
// Sequence: a read waits for the registered memory read, and a carriage return goes straight to
// the result; a put writes its cell and a plain newline steps the row; a tab writes spaces up to
// the next stop, a scrolling newline refills a row, and a put that wraps also runs a newline.
// busy falls as the result appears. Scrolling moves a row offset and refills one row.
// Reset starts a clearing pass over all ROWS*COLS cells (2000 by default) with busy high.
// The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
// Text terminal cell writer
// Character grid with cursor, wrap, tab, newline and row-offset scrolling,
// built around one modular adder and a small sequencer.
// ----------------------------------------------------------------------------
module text_terminal_cell_writer #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ttcw_pkg::req_t req,
  output logic           done,
  output ttcw_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);

  import ttcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int TW    = $clog2(TAB_STOP + 1);

  localparam logic [AW-1:0] COLS_A     = AW'(COLS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLS - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [TW-1:0] LAST_PHASE = TW'(TAB_STOP - 1);

  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_PUT       = 3'd2;
  localparam logic [2:0] S_NEWLINE   = 3'd3;
  localparam logic [2:0] S_FILL      = 3'd4;
  localparam logic [2:0] S_READ_WAIT = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0]    state;
  logic [7:0]    text_attr;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [TW-1:0] phase;
  logic [AW-1:0] line_start;
  logic [AW-1:0] pline;
  logic [AW-1:0] top_base;
  logic [AW-1:0] fill_ptr;
  logic [CW-1:0] fill_cnt;
  logic [7:0]    put_ch;
  logic          tab_mode;

  logic [AW-1:0] add_a;
  logic [AW-1:0] add_b;
  logic [AW-1:0] add_y;
  logic [AW-1:0] cur_lin;
  logic [TW-1:0] phase_next;
  logic          addr_ok;
  logic [AW-1:0] addr_local;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  cell_t         mem_rdata;

  assign busy       = (state != S_IDLE);
  assign cur_lin    = line_start + AW'(col);
  assign phase_next = (phase == LAST_PHASE) ? '0 : phase + 1'b1;
  assign addr_ok    = (32'(req.cell_address) < 32'(CELLS));
  assign addr_local = AW'(req.cell_address);

  always_comb begin
    add_a = pline;
    add_b = COLS_A;
    case (state)
      S_IDLE: begin
        add_a = addr_local;
        add_b = top_base;
      end
      S_NEWLINE: begin
        add_a = (row == LAST_ROW) ? top_base : pline;
        add_b = COLS_A;
      end
      default: begin
        add_a = pline;
        add_b = COLS_A;
      end
    endcase
  end

  ttcw_mod_add #(
    .W   (AW),
    .MOD (CELLS)
  ) u_mod_add (
    .a (add_a),
    .b (add_b),
    .y (add_y)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_ptr;
    mem_wdata = CELL_BLANK;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pline + AW'(col);
        mem_wdata = '{attr: text_attr, ch: put_ch};
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = '{attr: text_attr, ch: CH_SPACE};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  ttcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_screen_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (add_y),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr <= ATTR_RESET;
    end else if (cfg_we) begin
      text_attr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      row        <= '0;
      col        <= '0;
      phase      <= '0;
      line_start <= '0;
      pline      <= '0;
      top_base   <= '0;
      fill_ptr   <= '0;
      fill_cnt   <= '0;
      tab_mode   <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          fill_ptr <= fill_ptr + 1'b1;
          if (fill_ptr == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            put_ch   <= (req.char_code == CH_TAB) ? CH_SPACE : req.char_code;
            tab_mode <= (req.char_code == CH_TAB);
            if (req.cmd == CMD_READ) begin
              state <= addr_ok ? S_READ_WAIT : S_DONE;
            end else if (req.char_code == CH_LF) begin
              state <= S_NEWLINE;
            end else if (req.char_code == CH_CR) begin
              col   <= '0;
              phase <= '0;
              state <= S_DONE;
            end else begin
              state <= S_PUT;
            end
          end
        end
        S_PUT: begin
          if (col == LAST_COL) begin
            state <= S_NEWLINE;
          end else begin
            col   <= col + 1'b1;
            phase <= phase_next;
            if (!(tab_mode && (phase_next != '0))) begin
              state <= S_DONE;
            end
          end
        end
        S_NEWLINE: begin
          col   <= '0;
          phase <= '0;
          if (row == LAST_ROW) begin
            pline    <= top_base;
            fill_ptr <= top_base;
            top_base <= add_y;
            fill_cnt <= '0;
            state    <= S_FILL;
          end else begin
            row        <= row + 1'b1;
            line_start <= line_start + COLS_A;
            pline      <= add_y;
            state      <= S_DONE;
          end
        end
        S_FILL: begin
          fill_ptr <= fill_ptr + 1'b1;
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt == LAST_COL) begin
            state <= S_DONE;
          end
        end
        S_READ_WAIT: begin
          rsp.cell_char      <= mem_rdata.ch;
          rsp.cell_attribute <= mem_rdata.attr;
          rsp.cursor_pos     <= 11'(cur_lin);
          done               <= 1'b1;
          state              <= S_IDLE;
        end
        S_DONE: begin
          rsp.cell_char      <= '0;
          rsp.cell_attribute <= '0;
          rsp.cursor_pos     <= 11'(cur_lin);
          done               <= 1'b1;
          state              <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("Result strobe without a request in progress.");

  a_done_frees_block: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Block still busy when its result is shown.");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Accepted request did not start the sequencer.");

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |-> ((col <= LAST_COL) && (row <= LAST_ROW)))
    else $error("Cursor left the grid during a put.");
`endif

endmodule

// ----- src/ttcw_mod_add.sv -----
// ----------------------------------------------------------------------------
// Modular adder
// Adds two operands below MOD and folds the sum back into the range 0..MOD-1.
// ----------------------------------------------------------------------------
module ttcw_mod_add #(
  parameter int W   = 11,
  parameter int MOD = 2000
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] y
);

  localparam logic [W:0] MOD_X = (W+1)'(MOD);

  logic [W:0] sum;
  logic [W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = sum - MOD_X;
  assign y    = (sum >= MOD_X) ? diff[W-1:0] : sum[W-1:0];

endmodule

// ----- src/ttcw_screen_mem.sv -----
// ----------------------------------------------------------------------------
// Screen cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ttcw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ttcw_pkg::cell_t wdata,
  input  logic [AW-1:0]   raddr,
  output ttcw_pkg::cell_t rdata
);

  import ttcw_pkg::*;

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/sv/cell_writer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text terminal cell writer checker
// Watches the request, result and attribute ports and keeps its own copy of
// the character grid, cursor and attribute. It predicts the result of every
// accepted request and compares each strobed result with the oldest one.
// ----------------------------------------------------------------------------
module cell_writer_checker #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  ttcw_pkg::req_t req,
  input  logic           done,
  input  ttcw_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata,
  output int             mismatch_count,
  output int             pending_count
);
  import ttcw_pkg::*;

  localparam int CELLS = COLS * ROWS;

  cell_t       screen [CELLS];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0]  text_attr;
  rsp_t        pending_rsp [$];

  function automatic cell_t make_cell(logic [7:0] ch);
    return '{attr: text_attr, ch: ch};
  endfunction

  function automatic void reset_grid();
    text_attr = ATTR_RESET;
    cur_row   = 0;
    cur_col   = 0;
    for (int i = 0; i < CELLS; i++) screen[i] = make_cell(CH_SPACE);
  endfunction

  function automatic void scroll_up();
    for (int i = COLS; i < CELLS; i++) screen[i - COLS] = screen[i];
    for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = make_cell(CH_SPACE);
    cur_row = ROWS - 1;
  endfunction

  function automatic void new_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) scroll_up();
  endfunction

  function automatic void put_printable(logic [7:0] ch);
    int unsigned idx;
    idx = cur_row * COLS + cur_col;
    if (idx < CELLS) screen[idx] = make_cell(ch);
    cur_col++;
    if (cur_col >= COLS) new_line();
  endfunction

  function automatic void put_char(logic [7:0] ch);
    if (ch == CH_LF) begin
      new_line();
    end else if (ch == CH_CR) begin
      cur_col = 0;
    end else if (ch == CH_TAB) begin
      do begin
        put_printable(CH_SPACE);
      end while ((cur_col % TAB_STOP) != 0);
    end else begin
      put_printable(ch);
    end
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t p;
    p = '0;
    if (r.cmd == CMD_PUT) begin
      put_char(r.char_code);
    end else if (r.cell_address < CELLS) begin
      p.cell_char      = screen[r.cell_address].ch;
      p.cell_attribute = screen[r.cell_address].attr;
    end
    p.cursor_pos = 11'(cur_row * COLS + cur_col);
    return p;
  endfunction

  task automatic note_mismatch(string what, rsp_t want, rsp_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected char %02h attr %02h cursor %0d, %s %02h attr %02h cursor %0d",
               $time, what, want.cell_char, want.cell_attribute, want.cursor_pos,
               "got char", got.cell_char, got.cell_attribute, got.cursor_pos);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      reset_grid();
      pending_rsp.delete();
    end else begin
      if (done) begin
        if (pending_rsp.size() == 0) begin
          note_mismatch("unexpected result", '0, rsp);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.cell_char !== want.cell_char ||
              rsp.cell_attribute !== want.cell_attribute ||
              rsp.cursor_pos !== want.cursor_pos) begin
            note_mismatch("result mismatch", want, rsp);
          end
        end
      end
      if (start && !busy) pending_rsp.push_back(predict_rsp(req));
      if (cfg_we) text_attr = cfg_wdata;
    end
    pending_count = pending_rsp.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text terminal cell writer testbench
// Drives directed and random put and read requests over several attribute
// settings with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import ttcw_pkg::*;

  localparam int COLS         = 80;
  localparam int ROWS         = 25;
  localparam int TAB_STOP     = 4;
  localparam int CELLS        = COLS * ROWS;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 72;

  typedef enum int {MIX_TEXT, MIX_WRAP, MIX_SCROLL} mix_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  logic       busy;
  req_t       req       = '0;
  logic       done;
  rsp_t       rsp;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;
  int         mismatch_count;
  int         pending_count;
  int         idle_cycles = 0;
  bit         idling;

  always #5 clk = ~clk;

  text_terminal_cell_writer #(
    .COLS(COLS), .ROWS(ROWS), .TAB_STOP(TAB_STOP)
  ) uut (
    .clk, .rst, .start, .busy, .req, .done, .rsp, .cfg_we, .cfg_wdata
  );

  cell_writer_checker #(
    .COLS(COLS), .ROWS(ROWS), .TAB_STOP(TAB_STOP)
  ) grid_check (
    .clk, .rst, .start, .busy, .req, .done, .rsp, .cfg_we, .cfg_wdata,
    .mismatch_count, .pending_count
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t put_req(logic [7:0] ch);
    return '{cmd: CMD_PUT, char_code: ch, cell_address: '1};
  endfunction

  function automatic req_t read_req(logic [10:0] addr);
    return '{cmd: CMD_READ, char_code: 8'($urandom), cell_address: addr};
  endfunction

  function automatic req_t random_req(mix_t mix);
    req_t r;
    int   pick;
    int   lf_weight;
    int   cr_weight;
    lf_weight = (mix == MIX_SCROLL) ? 35 : (mix == MIX_WRAP) ? 1 : 8;
    cr_weight = (mix == MIX_WRAP) ? 1 : 3;
    r.cmd          = CMD_PUT;
    r.char_code    = 8'($urandom);
    r.cell_address = 11'($urandom);
    pick = $urandom_range(99);
    if (pick < 20) begin
      r.cmd = CMD_READ;
      if ($urandom_range(3) != 0) r.cell_address = 11'($urandom_range(CELLS - 1));
    end else if (pick < 20 + lf_weight) begin
      r.char_code = CH_LF;
    end else if (pick < 20 + lf_weight + cr_weight) begin
      r.char_code = CH_CR;
    end else if (pick < 28 + lf_weight + cr_weight) begin
      r.char_code = CH_TAB;
    end
    return r;
  endfunction

  task automatic send_req(req_t r);
    int gap;
    gap = idling ? $urandom_range(7) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req   <= r;
    start <= 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_attr(logic [7:0] value);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] attr_value;
    mix_t       mix;
    idling = 1'b1;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send_req(read_req(11'd0));
    send_req(read_req(11'(CELLS - 1)));
    send_req(read_req(11'(CELLS)));
    send_req(read_req(11'd2047));
    send_req(put_req(8'h41));
    send_req(put_req(8'h00));
    send_req(put_req(8'hFF));
    send_req(put_req(CH_TAB));
    send_req(put_req(CH_TAB));
    send_req(read_req(11'd3));
    send_req(put_req(CH_CR));
    send_req(read_req(11'd0));
    send_req(put_req(CH_LF));
    send_req(read_req(11'd2));
    send_req(put_req(CH_LF));

    for (int p = 0; p < PHASES; p++) begin
      attr_value = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom);
      mix        = mix_t'(p % 3);
      idling     = (p != 2 && p != 3);
      write_attr(attr_value);
      for (int i = 0; i < PHASE_ITEMS; i++) send_req(random_req(mix));
    end

    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ttcw_pkg.sv
src/ttcw_mod_add.sv
src/ttcw_screen_mem.sv
src/text_terminal_cell_writer.sv
tb/sv/cell_writer_checker.sv
tb/sv/testbench.sv
